/* rtl/swcl_pkg.sv */
// Shared types and constants for the single-wire command link.
package swcl_pkg;

    localparam int CMD_W = 3;
    localparam int TICK_W = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_BIT_PERIOD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_BIT = 1'd1;

    localparam logic [TICK_W-1:0] BIT_PERIOD_RST = 16'd50;
    localparam logic [TICK_W-1:0] HALF_BIT_RST = 16'd25;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_TX,
        MODE_RX
    } t_link_mode;

    typedef enum logic [1:0] {
        PH_START,
        PH_DATA,
        PH_STOP,
        PH_TAIL
    } t_frame_phase;

    typedef struct packed {
        logic             line_drive;
        logic             busy_res;
        logic             send_done;
        logic             receive_done;
        logic [CMD_W-1:0] received_command;
        logic             frame_error;
    } t_swcl_res;

endpackage

/* rtl/swcl_tick_if.sv */
// Channel that carries one sampling tick of the wire per transaction.
interface swcl_tick_if;
    logic                      valid;
    logic                      ready;
    logic                      line_level;
    logic                      send_request;
    logic [swcl_pkg::CMD_W-1:0] send_command;

    modport source (output valid, line_level, send_request, send_command, input ready);
    modport sink (input valid, line_level, send_request, send_command, output ready);
endinterface

/* rtl/swcl_res_if.sv */
// Channel that carries the link outputs for one tick per transaction.
interface swcl_res_if;
    logic                      valid;
    logic                      ready;
    logic                      line_drive;
    logic                      busy_res;
    logic                      send_done;
    logic                      receive_done;
    logic [swcl_pkg::CMD_W-1:0] received_command;
    logic                      frame_error;

    modport source (
        output valid, line_drive, busy_res, send_done, receive_done, received_command,
               frame_error,
        input  ready
    );
    modport sink (
        input  valid, line_drive, busy_res, send_done, receive_done, received_command,
               frame_error,
        output ready
    );
endinterface

/* rtl/single_wire_command_link_top.sv */
// Single-wire command link: tick-by-tick transmit and receive of framed commands.
// A tick transaction is registered on acceptance; its result is registered in the output buffer when it has room.
// From tick acceptance, a result goes through one input register before it enters the output buffer.
// Throughput is one tick per cycle while results are taken, held by a two-entry output buffer (main plus skid).
// Synchronous active-low reset sets 50 and 25 ticks, an idle link and a released line.
module single_wire_command_link_top #(
    parameter int DATA_BITS = 3
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [swcl_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [swcl_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    swcl_tick_if.sink                           i_tick,
    swcl_res_if.source                          o_res
);

    localparam int BI_W = $clog2(DATA_BITS + 1);

    logic [swcl_pkg::TICK_W-1:0] r_bit_period;
    logic [swcl_pkg::TICK_W-1:0] r_half_bit;

    logic                        r_in_vld;
    logic                        r_in_line;
    logic                        r_in_req;
    logic [swcl_pkg::CMD_W-1:0]  r_in_cmd;

    swcl_pkg::t_link_mode        r_mode, n_mode;
    swcl_pkg::t_frame_phase      r_phase, n_phase;
    logic [swcl_pkg::TICK_W-1:0] r_tick, n_tick;
    logic [BI_W-1:0]             r_bidx, n_bidx;
    logic [DATA_BITS-1:0]        r_shift, n_shift;
    logic                        r_drive, n_drive;

    swcl_pkg::t_swcl_res         w_res;
    swcl_pkg::t_swcl_res         r_main;
    swcl_pkg::t_swcl_res         r_skid;
    logic [1:0]                  r_cnt;

    logic                        w_step;
    logic                        w_pop;
    logic                        w_in_ready;
    logic [swcl_pkg::TICK_W-1:0] w_per;
    logic [swcl_pkg::TICK_W-1:0] w_half;

    assign w_step     = r_in_vld && (r_cnt != 2'd2);
    assign w_in_ready = !r_in_vld || w_step;
    assign w_pop      = (r_cnt != 2'd0) && o_res.ready;

    assign i_tick.ready = w_in_ready;

    assign w_per  = (r_bit_period == '0) ? swcl_pkg::TICK_W'(1) : r_bit_period;
    assign w_half = (r_half_bit == '0) ? swcl_pkg::TICK_W'(1) : r_half_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_period <= swcl_pkg::BIT_PERIOD_RST;
            r_half_bit   <= swcl_pkg::HALF_BIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                swcl_pkg::CFG_BIT_PERIOD: r_bit_period <= i_cfg_data;
                swcl_pkg::CFG_HALF_BIT:   r_half_bit   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_in_ready) begin
            r_in_vld <= i_tick.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_tick.valid) begin
            r_in_line <= i_tick.line_level;
            r_in_req  <= i_tick.send_request;
            r_in_cmd  <= i_tick.send_command;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= swcl_pkg::MODE_IDLE;
            r_phase <= swcl_pkg::PH_START;
            r_tick  <= '0;
            r_bidx  <= '0;
            r_shift <= '0;
            r_drive <= 1'b1;
        end else if (w_step) begin
            r_mode  <= n_mode;
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_bidx  <= n_bidx;
            r_shift <= n_shift;
            r_drive <= n_drive;
        end
    end

    always_comb begin
        logic rx_started;
        logic rx_done;
        n_mode  = r_mode;
        n_phase = r_phase;
        n_tick  = r_tick;
        n_bidx  = r_bidx;
        n_shift = r_shift;
        n_drive = r_drive;
        rx_started = 1'b0;
        rx_done    = 1'b0;
        w_res = '{line_drive: 1'b1, busy_res: 1'b0, send_done: 1'b0, receive_done: 1'b0,
                  received_command: '0, frame_error: 1'b0};

        if (n_mode == swcl_pkg::MODE_IDLE) begin
            n_phase = swcl_pkg::PH_START;
            n_tick  = '0;
            n_bidx  = '0;
            n_drive = 1'b1;
            if (r_in_req) begin
                n_mode  = swcl_pkg::MODE_TX;
                n_drive = 1'b0;
                n_shift = DATA_BITS'(r_in_cmd);
            end else if (!r_in_line) begin
                n_mode     = swcl_pkg::MODE_RX;
                rx_started = 1'b1;
                w_res.busy_res = 1'b1;
            end
        end

        if (n_mode == swcl_pkg::MODE_TX) begin
            w_res.line_drive = n_drive;
            w_res.busy_res   = 1'b1;
            n_tick = n_tick + swcl_pkg::TICK_W'(1);
            if (n_tick >= w_per) begin
                n_tick = '0;
                unique case (n_phase)
                    swcl_pkg::PH_START: begin
                        n_phase = swcl_pkg::PH_DATA;
                        n_bidx  = '0;
                        n_drive = n_shift[0];
                        n_shift = n_shift >> 1;
                    end
                    swcl_pkg::PH_DATA: begin
                        n_bidx = n_bidx + BI_W'(1);
                        if (n_bidx >= BI_W'(DATA_BITS)) begin
                            n_phase = swcl_pkg::PH_STOP;
                            n_drive = 1'b1;
                        end else begin
                            n_drive = n_shift[0];
                            n_shift = n_shift >> 1;
                        end
                    end
                    default: begin
                        w_res.send_done = 1'b1;
                        n_mode  = swcl_pkg::MODE_IDLE;
                        n_phase = swcl_pkg::PH_START;
                        n_bidx  = '0;
                        n_drive = 1'b1;
                    end
                endcase
            end
        end else if (n_mode == swcl_pkg::MODE_RX && !rx_started) begin
            w_res.busy_res = 1'b1;
            n_tick = n_tick + swcl_pkg::TICK_W'(1);
            unique case (n_phase)
                swcl_pkg::PH_START: begin
                    if (n_tick >= w_half) begin
                        if (!r_in_line) begin
                            n_phase = swcl_pkg::PH_DATA;
                            n_tick  = '0;
                            n_bidx  = '0;
                            n_shift = '0;
                        end else begin
                            rx_done = 1'b1;
                            w_res.frame_error = 1'b1;
                        end
                    end
                end
                swcl_pkg::PH_DATA: begin
                    if (n_tick >= w_per) begin
                        n_shift = (n_shift << 1) | DATA_BITS'(r_in_line);
                        n_tick  = '0;
                        n_bidx  = n_bidx + BI_W'(1);
                        if (n_bidx >= BI_W'(DATA_BITS)) begin
                            n_phase = swcl_pkg::PH_STOP;
                        end
                    end
                end
                swcl_pkg::PH_STOP: begin
                    if (n_tick >= w_per) begin
                        if (r_in_line) begin
                            n_phase = swcl_pkg::PH_TAIL;
                            n_tick  = '0;
                        end else begin
                            rx_done = 1'b1;
                            w_res.frame_error = 1'b1;
                        end
                    end
                end
                swcl_pkg::PH_TAIL: begin
                    if (n_tick >= w_half) begin
                        rx_done = 1'b1;
                        w_res.received_command = swcl_pkg::CMD_W'(n_shift);
                    end
                end
                default: ;
            endcase
            if (rx_done) begin
                w_res.receive_done = 1'b1;
                n_mode  = swcl_pkg::MODE_IDLE;
                n_phase = swcl_pkg::PH_START;
                n_tick  = '0;
                n_bidx  = '0;
                n_drive = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= r_cnt + {1'b0, w_step} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            if (r_cnt == 2'd0 || w_pop) begin
                r_main <= w_res;
            end else begin
                r_skid <= w_res;
            end
        end else if (w_pop && r_cnt == 2'd2) begin
            r_main <= r_skid;
        end
    end

    assign o_res.valid            = (r_cnt != 2'd0);
    assign o_res.line_drive       = r_main.line_drive;
    assign o_res.busy_res         = r_main.busy_res;
    assign o_res.send_done        = r_main.send_done;
    assign o_res.receive_done     = r_main.receive_done;
    assign o_res.received_command = r_main.received_command;
    assign o_res.frame_error      = r_main.frame_error;

endmodule

/* rtl/swcl_checker.sv */
// Port-level checks on the command link results, bound to the top level.
module swcl_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic                       i_send_done,
    input logic                       i_receive_done,
    input logic                       i_busy_res,
    input logic [swcl_pkg::CMD_W-1:0] i_received_command,
    input logic                       i_frame_error
);

    a_no_valid_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("Result transaction valid right after reset.");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("Result transaction dropped while stalled.");

    a_error_needs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_frame_error || i_received_command != '0) |-> i_receive_done)
        else $error("Receive status shown without a finished receive.");

    a_one_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_send_done || i_receive_done) |->
            i_busy_res && !(i_send_done && i_receive_done))
        else $error("Completion flags inconsistent.");

    a_cmd_clean_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_frame_error |-> i_received_command == '0)
        else $error("Command reported on a framing failure.");

endmodule

bind single_wire_command_link_top swcl_checker u_swcl_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_out_valid        (o_res.valid),
    .i_out_ready        (o_res.ready),
    .i_send_done        (o_res.send_done),
    .i_receive_done     (o_res.receive_done),
    .i_busy_res         (o_res.busy_res),
    .i_received_command (o_res.received_command),
    .i_frame_error      (o_res.frame_error)
);

/* verif/single_wire_command_link_top_test.sv */
// Self-checking test of the single-wire command link: sends and receives framed commands.
`timescale 1ns / 100ps

module single_wire_command_link_top_test;

    localparam int FRAME_BITS = 3;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT = 250000;
    localparam int HOLD_AT = 150;
    localparam int HOLD_CYCLES = 300;
    localparam int SIDE_TICK = 0;
    localparam int SIDE_RES = 1;
    localparam int N_PHASES = 5;

    localparam swcl_pkg::t_swcl_res IDLE_RES = 8'b1_0_0_0_000_0;
    localparam swcl_pkg::t_swcl_res FRAMING_ERR = 8'b1_1_0_1_000_1;

    localparam logic [swcl_pkg::TICK_W-1:0] PHASE_PERIOD [N_PHASES] =
        '{16'd2, 16'd3, 16'd4, 16'd6, 16'd8};
    localparam logic [swcl_pkg::TICK_W-1:0] PHASE_HALF [N_PHASES] =
        '{16'd1, 16'd1, 16'd2, 16'd5, 16'd4};

    typedef struct packed {
        logic                       line;
        logic                       req;
        logic [swcl_pkg::CMD_W-1:0] cmd;
        logic [7:0]                 reps;
        logic                       typed;
        swcl_pkg::t_swcl_res        want;
    } t_stim_row;

    // Written with both registers at zero, so every bit and half bit lasts one tick.
    localparam int N_ROWS = 19;
    localparam t_stim_row DIRECTED_ROWS [N_ROWS] = '{
        '{1'b1, 1'b0, 3'd0, 8'd2, 1'b1, IDLE_RES},
        '{1'b1, 1'b1, 3'd7, 8'd1, 1'b0, IDLE_RES},
        '{1'b0, 1'b1, 3'd2, 8'd1, 1'b0, IDLE_RES},
        '{1'b0, 1'b0, 3'd0, 8'd3, 1'b0, IDLE_RES},
        '{1'b1, 1'b0, 3'd0, 8'd1, 1'b1, IDLE_RES},
        '{1'b0, 1'b1, 3'd0, 8'd1, 1'b0, IDLE_RES},
        '{1'b1, 1'b0, 3'd0, 8'd4, 1'b0, IDLE_RES},
        '{1'b0, 1'b0, 3'd0, 8'd2, 1'b0, IDLE_RES},
        '{1'b1, 1'b0, 3'd0, 8'd2, 1'b0, IDLE_RES},
        '{1'b0, 1'b0, 3'd0, 8'd1, 1'b0, IDLE_RES},
        '{1'b1, 1'b0, 3'd0, 8'd2, 1'b0, IDLE_RES},
        '{1'b0, 1'b0, 3'd0, 8'd1, 1'b0, IDLE_RES},
        '{1'b1, 1'b0, 3'd0, 8'd1, 1'b1, FRAMING_ERR},
        '{1'b0, 1'b0, 3'd0, 8'd2, 1'b0, IDLE_RES},
        '{1'b1, 1'b0, 3'd0, 8'd1, 1'b0, IDLE_RES},
        '{1'b0, 1'b0, 3'd0, 8'd1, 1'b0, IDLE_RES},
        '{1'b1, 1'b0, 3'd0, 8'd1, 1'b0, IDLE_RES},
        '{1'b0, 1'b0, 3'd0, 8'd1, 1'b1, FRAMING_ERR},
        '{1'b1, 1'b0, 3'd0, 8'd1, 1'b1, IDLE_RES}
    };

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [swcl_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [swcl_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    swcl_tick_if tick_ch ();
    swcl_res_if res_ch ();

    single_wire_command_link_top #(
        .DATA_BITS(FRAME_BITS)
    ) u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_tick(tick_ch),
        .o_res(res_ch)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Link state mirrored tick by tick.
    swcl_pkg::t_link_mode lk_mode = swcl_pkg::MODE_IDLE;
    swcl_pkg::t_frame_phase lk_phase = swcl_pkg::PH_START;
    logic [swcl_pkg::TICK_W-1:0] lk_count = '0;
    logic [1:0] lk_bit = '0;
    logic [3:0] lk_shift = '0;
    logic lk_drive = 1'b1;
    logic [swcl_pkg::TICK_W-1:0] cfg_period = swcl_pkg::BIT_PERIOD_RST;
    logic [swcl_pkg::TICK_W-1:0] cfg_half = swcl_pkg::HALF_BIT_RST;

    swcl_pkg::t_swcl_res link_outputs_q [$];
    int n_sent = 0;
    int n_results = 0;
    int n_mismatch = 0;
    int n_cycles = 0;
    int calm_left [2] = '{0, 0};

    function automatic void link_release();
        lk_mode = swcl_pkg::MODE_IDLE;
        lk_phase = swcl_pkg::PH_START;
        lk_count = '0;
        lk_bit = '0;
        lk_drive = 1'b1;
    endfunction

    function automatic swcl_pkg::t_swcl_res link_tick(input logic line, input logic req,
                                                      input logic [swcl_pkg::CMD_W-1:0] cmd);
        swcl_pkg::t_swcl_res res;
        logic [swcl_pkg::TICK_W-1:0] per;
        logic [swcl_pkg::TICK_W-1:0] half;
        logic rx_new;
        logic rx_end;
        per = (cfg_period == '0) ? swcl_pkg::TICK_W'(1) : cfg_period;
        half = (cfg_half == '0) ? swcl_pkg::TICK_W'(1) : cfg_half;
        res = IDLE_RES;
        rx_new = 1'b0;
        rx_end = 1'b0;
        if (lk_mode != swcl_pkg::MODE_TX && lk_mode != swcl_pkg::MODE_RX) begin
            link_release();
            if (req) begin
                lk_mode = swcl_pkg::MODE_TX;
                lk_drive = 1'b0;
                lk_shift = {1'b0, cmd};
            end else if (!line) begin
                lk_mode = swcl_pkg::MODE_RX;
                rx_new = 1'b1;
                res.busy_res = 1'b1;
            end
        end
        if (lk_mode == swcl_pkg::MODE_TX) begin
            res.line_drive = lk_drive;
            res.busy_res = 1'b1;
            lk_count = lk_count + swcl_pkg::TICK_W'(1);
            if (lk_count >= per) begin
                lk_count = '0;
                case (lk_phase)
                    swcl_pkg::PH_START: begin
                        lk_phase = swcl_pkg::PH_DATA;
                        lk_bit = '0;
                        lk_drive = lk_shift[0];
                        lk_shift = lk_shift >> 1;
                    end
                    swcl_pkg::PH_DATA: begin
                        lk_bit = lk_bit + 2'd1;
                        if (lk_bit >= 2'(FRAME_BITS)) begin
                            lk_phase = swcl_pkg::PH_STOP;
                            lk_drive = 1'b1;
                        end else begin
                            lk_drive = lk_shift[0];
                            lk_shift = lk_shift >> 1;
                        end
                    end
                    default: begin
                        res.send_done = 1'b1;
                        link_release();
                    end
                endcase
            end
        end else if (lk_mode == swcl_pkg::MODE_RX && !rx_new) begin
            res.busy_res = 1'b1;
            lk_count = lk_count + swcl_pkg::TICK_W'(1);
            case (lk_phase)
                swcl_pkg::PH_START: begin
                    if (lk_count >= half) begin
                        if (!line) begin
                            lk_phase = swcl_pkg::PH_DATA;
                            lk_count = '0;
                            lk_bit = '0;
                            lk_shift = '0;
                        end else begin
                            rx_end = 1'b1;
                            res.frame_error = 1'b1;
                        end
                    end
                end
                swcl_pkg::PH_DATA: begin
                    if (lk_count >= per) begin
                        lk_shift = {1'b0, lk_shift[1:0], line};
                        lk_count = '0;
                        lk_bit = lk_bit + 2'd1;
                        if (lk_bit >= 2'(FRAME_BITS)) begin
                            lk_phase = swcl_pkg::PH_STOP;
                        end
                    end
                end
                swcl_pkg::PH_STOP: begin
                    if (lk_count >= per) begin
                        if (line) begin
                            lk_phase = swcl_pkg::PH_TAIL;
                            lk_count = '0;
                        end else begin
                            rx_end = 1'b1;
                            res.frame_error = 1'b1;
                        end
                    end
                end
                default: begin
                    if (lk_count >= half) begin
                        rx_end = 1'b1;
                        res.received_command = lk_shift[swcl_pkg::CMD_W-1:0];
                    end
                end
            endcase
            if (rx_end) begin
                res.receive_done = 1'b1;
                link_release();
            end
        end
        return res;
    endfunction

    function automatic int draw_wait(input int side);
        if (calm_left[side] > 0) begin
            calm_left[side]--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            calm_left[side] = $urandom_range(20, 120);
            return 0;
        end
        return $urandom_range(0, 11);
    endfunction

    task automatic report_mismatch(input string msg);
        if (n_mismatch < 100) begin
            $display("MISMATCH: %s", msg);
        end
        n_mismatch++;
    endtask

    task automatic check_field(input string field, input logic [7:0] got, input logic [7:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d %s got %0h want %0h", n_results, field, got,
                                      want));
        end
    endtask

    task automatic put_tick(input logic line, input logic req,
                            input logic [swcl_pkg::CMD_W-1:0] cmd,
                            input logic typed = 1'b0, input swcl_pkg::t_swcl_res want = '0);
        int gap;
        swcl_pkg::t_swcl_res outputs;
        gap = draw_wait(SIDE_TICK);
        if (gap > 0) begin
            tick_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        tick_ch.valid <= 1'b1;
        tick_ch.line_level <= line;
        tick_ch.send_request <= req;
        tick_ch.send_command <= cmd;
        do @(posedge i_clk); while (!tick_ch.ready);
        outputs = link_tick(line, req, cmd);
        link_outputs_q.push_back(typed ? want : outputs);
        n_sent++;
    endtask

    task automatic finish_phase();
        while (lk_mode != swcl_pkg::MODE_IDLE) begin
            put_tick(1'b1, 1'b0, '0);
        end
        tick_ch.valid <= 1'b0;
        do @(posedge i_clk); while (link_outputs_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_link(input logic [swcl_pkg::TICK_W-1:0] period,
                                input logic [swcl_pkg::TICK_W-1:0] half);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= swcl_pkg::CFG_BIT_PERIOD;
        i_cfg_data <= period;
        @(posedge i_clk);
        i_cfg_idx <= swcl_pkg::CFG_HALF_BIT;
        i_cfg_data <= half;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_period = period;
        cfg_half = half;
    endtask

    task automatic run_traffic(input int n_items);
        int stop_at;
        int per;
        int half;
        int act;
        int len;
        logic [swcl_pkg::CMD_W-1:0] bits;
        logic level;
        stop_at = n_sent + n_items;
        per = (cfg_period == '0) ? 1 : int'(cfg_period);
        half = (cfg_half == '0) ? 1 : int'(cfg_half);
        while (n_sent < stop_at) begin
            act = $urandom_range(0, 9);
            bits = swcl_pkg::CMD_W'($urandom);
            if (act < 5 || act == 7) begin
                // A whole frame on the wire; the stop bit is held low for some of them.
                for (int seg = 0; seg < FRAME_BITS + 2; seg++) begin
                    if (seg == 0) begin
                        level = 1'b0;
                    end else if (seg == FRAME_BITS + 1) begin
                        level = (act != 7);
                    end else begin
                        level = bits[seg-1];
                    end
                    len = per;
                    if (per > 2 && $urandom_range(0, 3) == 0) begin
                        len = per + int'($urandom_range(0, 2)) - 1;
                    end
                    repeat (len) put_tick(level, 1'b0, '0);
                end
                repeat ($urandom_range(1, half + 2)) put_tick(1'b1, 1'b0, '0);
            end else if (act < 7) begin
                put_tick(1'($urandom), 1'b1, bits);
                repeat ((FRAME_BITS + 2) * per - 1) begin
                    put_tick(1'($urandom), $urandom_range(0, 7) == 0,
                             swcl_pkg::CMD_W'($urandom));
                end
                repeat ($urandom_range(1, 3)) put_tick(1'b1, 1'b0, '0);
            end else if (act == 8) begin
                repeat ($urandom_range(1, half)) put_tick(1'b0, 1'b0, '0);
                repeat (half + 2) put_tick(1'b1, 1'b0, '0);
            end else begin
                repeat ($urandom_range(1, 8)) begin
                    put_tick(1'($urandom), $urandom_range(0, 7) == 0,
                             swcl_pkg::CMD_W'($urandom));
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        int w;
        swcl_pkg::t_swcl_res want;
        res_ch.ready <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            w = (n_results == HOLD_AT) ? HOLD_CYCLES : draw_wait(SIDE_RES);
            if (w > 0) begin
                res_ch.ready <= 1'b0;
                repeat (w) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!res_ch.valid);
            if (link_outputs_q.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with no tick pending", n_results));
            end else begin
                want = link_outputs_q.pop_front();
                check_field("line_drive", 8'(res_ch.line_drive), 8'(want.line_drive));
                check_field("busy_res", 8'(res_ch.busy_res), 8'(want.busy_res));
                check_field("send_done", 8'(res_ch.send_done), 8'(want.send_done));
                check_field("receive_done", 8'(res_ch.receive_done), 8'(want.receive_done));
                check_field("received_command", 8'(res_ch.received_command),
                            8'(want.received_command));
                check_field("frame_error", 8'(res_ch.frame_error), 8'(want.frame_error));
            end
            n_results++;
        end
    end

    initial begin
        tick_ch.valid <= 1'b0;
        tick_ch.line_level <= 1'b1;
        tick_ch.send_request <= 1'b0;
        tick_ch.send_command <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_traffic(400);
        finish_phase();

        program_link('0, '0);
        for (int r = 0; r < N_ROWS; r++) begin
            repeat (DIRECTED_ROWS[r].reps) begin
                put_tick(DIRECTED_ROWS[r].line, DIRECTED_ROWS[r].req, DIRECTED_ROWS[r].cmd,
                         DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);
            end
        end
        finish_phase();

        for (int p = 0; p < N_PHASES; p++) begin
            program_link(PHASE_PERIOD[p], PHASE_HALF[p]);
            run_traffic(300);
            finish_phase();
        end

        program_link(16'hFFFF, 16'd1);
        repeat (3) put_tick(1'b1, 1'b0, '0);
        put_tick(1'b0, 1'b0, '0);
        put_tick(1'b1, 1'b0, '0, 1'b1, FRAMING_ERR);
        repeat (3) put_tick(1'b1, 1'b0, '0);
        finish_phase();

        program_link(16'd2, 16'hFFFF);
        put_tick(1'b1, 1'b1, swcl_pkg::CMD_W'($urandom));
        repeat (9) put_tick(1'b1, 1'($urandom), swcl_pkg::CMD_W'($urandom));
        repeat (3) put_tick(1'b1, 1'b0, '0);
        finish_phase();

        if (n_mismatch == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
